### design/mkdh_pkg.sv
// Package for the matrix keypad debouncer with hold detection.
// Holds the shared widths, register indexes and the configuration struct.
// Used by mkdh_cfg, mkdh_cell and matrix_keypad_debounce_hold.
package mkdh_pkg;

  // Largest matrix that the ports can carry, one bit per key.
  localparam int unsigned MaxKeys   = 16;
  localparam int unsigned KeyIdxW   = 4;
  localparam int unsigned DebW      = 8;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE_SCANS = 2'd0,
    CFG_HOLD_LIMIT     = 2'd1,
    CFG_STAR_KEY_INDEX = 2'd2
  } cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [DebW-1:0]    DebounceReset = 8'd3;
  localparam logic [HoldW-1:0]   HoldLimitReset = 16'd150;
  localparam logic [KeyIdxW-1:0] StarKeyReset  = 4'd11;

  // Saturation value of the per-key hold counter.
  localparam logic [HoldW-1:0]   HoldMax = 16'hFFFF;

  // Current configuration, shared by every key cell.
  typedef struct packed {
    logic [DebW-1:0]    debounce_scans;
    logic [HoldW-1:0]   hold_limit;
    logic [KeyIdxW-1:0] star_key_index;
  } cfg_t;

endpackage

### design/matrix_keypad_debounce_hold.sv
// Matrix keypad debouncer with star-key hold detection: one transaction per
// matrix snapshot in, one result transaction out, one per clock cycle unless
// the result channel stalls. Each key has its own cell; the hold request runs
// along the chain of cells. Depends on mkdh_pkg, mkdh_cfg and mkdh_cell.
//
// Each input transaction is one keypad snapshot (bit k set when key k, row
// major, is pressed). Every snapshot yields exactly one result in the next
// cycle, held in an output register, so a new snapshot is taken in every
// cycle while the result channel is not stalled. A key pressed for
// debounce_scans scans after its first seen scan gives a press event; later
// periods raise its hold count, and when the star key's count exceeds
// hold_limit, hold_reset is raised at each of its on events. Keys beyond
// NUM_ROWS*NUM_COLS (capped at 16) are ignored. Configuration writes are
// always accepted and should be made while the block is idle.
module matrix_keypad_debounce_hold
  import mkdh_pkg::*;
#(
  parameter int unsigned NUM_ROWS = 4,
  parameter int unsigned NUM_COLS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MaxKeys-1:0]  in_pressed_keys,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MaxKeys-1:0]  out_press_events,
  output logic                out_hold_reset,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int unsigned NumKeys =
    (NUM_ROWS * NUM_COLS > MaxKeys) ? MaxKeys : NUM_ROWS * NUM_COLS;

  cfg_t                cfg;
  logic                step;
  logic [MaxKeys-1:0]  events;
  logic [NumKeys:0]    hold_chain;

  logic                out_valid_r,  out_valid_nxt;
  logic [MaxKeys-1:0]  out_events_r;
  logic                out_hold_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  mkdh_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Accept a snapshot whenever the output register is free or being drained.
  assign in_stall = out_valid_r & out_stall;
  assign step     = in_valid & ~in_stall;

  // Chain of key cells.
  assign hold_chain[0] = 1'b0;

  for (genvar k = 0; k < NumKeys; k++) begin : g_key
    mkdh_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .step         (step),
      .pressed      (in_pressed_keys[k]),
      .is_star      (cfg.star_key_index == KeyIdxW'(k)),
      .cfg          (cfg),
      .hold_req_in  (hold_chain[k]),
      .press_event  (events[k]),
      .hold_req_out (hold_chain[k+1])
    );
  end

  if (NumKeys < MaxKeys) begin : g_pad
    assign events[MaxKeys-1:NumKeys] = '0;
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_events_r <= events;
      out_hold_r   <= hold_chain[NumKeys];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_press_events = out_events_r;
  assign out_hold_reset   = out_hold_r;

endmodule

### design/mkdh_cfg.sv
// Configuration register bank of the keypad debouncer.
// Decodes writes on the configuration channel into the cfg_t struct.
// Depends on mkdh_pkg.
module mkdh_cfg
  import mkdh_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register write decode; an index past the list is ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_DEBOUNCE_SCANS: cfg_nxt.debounce_scans = wr_data[DebW-1:0];
        CFG_HOLD_LIMIT:     cfg_nxt.hold_limit     = wr_data[HoldW-1:0];
        CFG_STAR_KEY_INDEX: cfg_nxt.star_key_index = wr_data[KeyIdxW-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_scans <= DebounceReset;
      cfg_r.hold_limit     <= HoldLimitReset;
      cfg_r.star_key_index <= StarKeyReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/mkdh_cell.sv
// One key cell of the debouncer chain: seen flag, debounce counter,
// pushed flag and hold counter of a single key, plus one link of the
// hold request chain. Depends on mkdh_pkg.
module mkdh_cell
  import mkdh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic pressed,
  input  logic is_star,
  input  cfg_t cfg,
  input  logic hold_req_in,
  output logic press_event,
  output logic hold_req_out
);

  logic             seen_r,   seen_nxt;
  logic [DebW-1:0]  cnt_r,    cnt_nxt;
  logic             pushed_r, pushed_nxt;
  logic [HoldW-1:0] hold_r,   hold_nxt;

  logic [DebW-1:0]  cnt_inc;
  logic [HoldW-1:0] hold_sat;
  logic             hold_req;

  assign cnt_inc  = cnt_r + DebW'(1);
  assign hold_sat = (hold_r == HoldMax) ? hold_r : hold_r + HoldW'(1);

  // Per-key scan update.
  always_comb begin
    seen_nxt    = seen_r;
    cnt_nxt     = cnt_r;
    pushed_nxt  = pushed_r;
    hold_nxt    = hold_r;
    press_event = 1'b0;
    hold_req    = 1'b0;
    if (!pressed) begin
      seen_nxt   = 1'b0;
      cnt_nxt    = '0;
      pushed_nxt = 1'b0;
      hold_nxt   = '0;
    end else if (!seen_r) begin
      seen_nxt = 1'b1;
    end else if (cnt_inc != cfg.debounce_scans) begin
      cnt_nxt = cnt_inc;
    end else begin
      // A full debounce period has passed: an on event.
      cnt_nxt = '0;
      if (pushed_r) begin
        hold_nxt = hold_sat;
        hold_req = is_star && (hold_sat > cfg.hold_limit);
      end else begin
        pushed_nxt  = 1'b1;
        hold_nxt    = '0;
        press_event = 1'b1;
      end
    end
  end

  assign hold_req_out = hold_req_in | hold_req;

  // State advances only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= 1'b0;
      cnt_r    <= '0;
      pushed_r <= 1'b0;
      hold_r   <= '0;
    end else if (step) begin
      seen_r   <= seen_nxt;
      cnt_r    <= cnt_nxt;
      pushed_r <= pushed_nxt;
      hold_r   <= hold_nxt;
    end
  end

endmodule
